// ===== rtl/nba_pkg.sv =====
package nba_pkg;

    localparam int DEF_RATE_BITS = 32;
    localparam int DEF_TIME_BITS = 32;

    localparam int FIELD_BITS = 32;
    localparam int S_DATA_BITS = 160;
    localparam int M_DATA_BITS = 72;
    localparam int CFG_INDEX_BITS = 2;
    localparam int WINDOW_BITS = 16;
    localparam int QW = 17;

    localparam logic [QW-1:0] Q_HALF = 17'd32768;
    localparam logic [QW-1:0] Q_P70 = 17'd45875;
    localparam logic [QW-1:0] Q_P80 = 17'd52428;
    localparam logic [QW-1:0] Q_UP1ST = 17'd84541;
    localparam logic [QW-1:0] Q_UP = 17'd85852;
    localparam logic [QW-1:0] Q_FORCE = 17'd64880;
    localparam logic [QW-1:0] Q_SEED = 17'd66191;
    localparam logic [QW-1:0] Q_DIVERG = 17'd85196;

    localparam int HOLD_ALL_MS = 1000;
    localparam int HOLD_DIR_MS = 7000;
    localparam int HOLD_UP_MS = 15000;
    localparam logic [FIELD_BITS-1:0] MIN_PKTS = 32'd250;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd10000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORCE = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP = 2'd2;

    typedef enum logic [2:0] {
        QC_NONE,
        QC_HALF,
        QC_P70,
        QC_P80,
        QC_UP1ST,
        QC_UP,
        QC_FORCE
    } qcode_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CUR_SEED,
        MUL_TGT_Q,
        MUL_CUR_Q,
        MUL_PROD_DIV,
        MUL_CUR_DIV,
        MUL_TGT_DIV
    } mul_sel_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic decide;
        mul_sel_t mul_sel;
        logic seed_wr;
        logic adj_wr;
        logic nt_latch;
        logic apply;
        logic div_chk;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic adjust;
        logic tgt_zero;
        logic div_cand;
        logic hold;
        logic step_up;
    } dp_sts_t;

    function automatic logic [QW-1:0] q_value(input qcode_t code);
        logic [QW-1:0] q;
        q = '0;
        unique case (code)
            QC_HALF: q = Q_HALF;
            QC_P70: q = Q_P70;
            QC_P80: q = Q_P80;
            QC_UP1ST: q = Q_UP1ST;
            QC_UP: q = Q_UP;
            QC_FORCE: q = Q_FORCE;
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

// ===== rtl/nba_ctrl.sv =====
module nba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output nba_pkg::dp_cmd_t cmd,
    input  nba_pkg::dp_sts_t sts
);
    import nba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_SEED_MUL,
        S_SEED_WR,
        S_ADJ,
        S_NT,
        S_CAP,
        S_APPLY,
        S_DIV_MUL,
        S_DIV_NEXT,
        S_DIV_CHK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MUL_NONE;
        state_next = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.skip)
                    state_next = S_FINISH;
                else if (sts.adjust)
                    state_next = sts.tgt_zero ? S_SEED_MUL : S_ADJ;
                else if (sts.div_cand)
                    state_next = S_DIV_MUL;
                else
                    state_next = S_FINISH;
            end
            S_SEED_MUL:
            begin
                cmd.mul_sel = MUL_CUR_SEED;
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                cmd.seed_wr = 1'b1;
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                cmd.adj_wr = 1'b1;
                if (sts.hold)
                    state_next = S_FINISH;
                else
                begin
                    cmd.mul_sel = MUL_TGT_Q;
                    state_next = S_NT;
                end
            end
            S_NT:
            begin
                cmd.nt_latch = 1'b1;
                if (sts.step_up)
                begin
                    cmd.mul_sel = MUL_CUR_Q;
                    state_next = S_CAP;
                end
                else
                    state_next = S_APPLY;
            end
            S_CAP:
            begin
                cmd.mul_sel = MUL_PROD_DIV;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                state_next = S_FINISH;
            end
            S_DIV_MUL:
            begin
                cmd.mul_sel = MUL_CUR_DIV;
                state_next = S_DIV_NEXT;
            end
            S_DIV_NEXT:
            begin
                cmd.nt_latch = 1'b1;
                cmd.mul_sel = MUL_TGT_DIV;
                state_next = S_DIV_CHK;
            end
            S_DIV_CHK:
            begin
                cmd.div_chk = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/nba_dp.sv =====
module nba_dp #(
    parameter int RATE_BITS = nba_pkg::DEF_RATE_BITS,
    parameter int TIME_BITS = nba_pkg::DEF_TIME_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [nba_pkg::S_DATA_BITS-1:0]      s_tdata,
    output logic [nba_pkg::M_DATA_BITS-1:0]      m_tdata,
    input  logic                                 cfg_wr,
    input  logic [nba_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [nba_pkg::FIELD_BITS-1:0]       cfg_data,
    input  nba_pkg::dp_cmd_t                     cmd,
    output nba_pkg::dp_sts_t                     sts
);
    import nba_pkg::*;

    localparam int EXT = RATE_BITS + 33;
    localparam int MA = RATE_BITS + 1;
    localparam int PW = RATE_BITS + 2;
    localparam int FULL = RATE_BITS + 18;
    localparam int NW = FIELD_BITS + 7;
    localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

    function automatic logic [RATE_BITS-1:0] sat_rate(input logic [EXT-1:0] v);
        return (v > EXT'(RATE_MAX)) ? RATE_MAX : v[RATE_BITS-1:0];
    endfunction

    logic [RATE_BITS-1:0] min_reg;
    logic [RATE_BITS-1:0] max_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic force_reg;

    logic [RATE_BITS-1:0] target_reg;
    logic [TIME_BITS-1:0] adj_time_reg;
    logic adj_seen_reg;
    logic [TIME_BITS-1:0] down_time_reg;
    logic down_seen_reg;
    logic [TIME_BITS-1:0] up_time_reg;
    logic up_seen_reg;

    logic [TIME_BITS-1:0] now_reg;
    logic [FIELD_BITS-1:0] pkts_reg;
    logic [FIELD_BITS-1:0] nacks_reg;
    logic [FIELD_BITS-1:0] dur_reg;
    logic [RATE_BITS-1:0] rate_in_reg;

    logic skip_reg;
    logic valid_reg;
    logic [RATE_BITS-1:0] cur_reg;
    logic [NW-1:0] n100_reg;
    logic down_gt_up_reg;
    logic down_lt_dir_reg;
    logic up_lt_dir_reg;

    qcode_t qcode_reg;
    logic hold_reg;
    logic step_up_reg;

    logic [PW-1:0] prod_reg;
    logic [MA-1:0] nt_reg;

    logic notify_reg;
    logic [1:0] dir_reg;

    logic [M_DATA_BITS-1:0] out_reg;

    logic [TIME_BITS-1:0] el_adj;
    logic [TIME_BITS-1:0] el_down;
    logic [TIME_BITS-1:0] el_up;
    logic [NW-1:0] nacks_ext;
    logic [NW-1:0] pkts_ext;

    qcode_t q_next;
    logic raise_ok;
    logic hold_next;
    logic up_next;

    logic [MA-1:0] mul_a;
    logic [QW-1:0] mul_q;
    logic [FULL-1:0] prod_full;

    logic [MA-1:0] prev_ext;
    logic [MA-1:0] nt_sel;
    logic [MA-1:0] nt_clamp;

    logic [EXT-1:0] tgt_ext;
    logic [EXT-1:0] cur_ext;
    logic [FIELD_BITS-1:0] tgt_out;
    logic [FIELD_BITS-1:0] rate_out;

    assign el_adj = now_reg - adj_time_reg;
    assign el_down = now_reg - down_time_reg;
    assign el_up = now_reg - up_time_reg;
    assign nacks_ext = NW'(nacks_reg);
    assign pkts_ext = NW'(pkts_reg);

    always_comb
    begin
        q_next = QC_NONE;
        raise_ok = 1'b1;
        if (nacks_reg != '0 && valid_reg)
        begin
            if (n100_reg >= (pkts_ext << 3))
                q_next = QC_HALF;
            else if (n100_reg > (pkts_ext << 2) + pkts_ext)
                q_next = QC_P70;
            else if (n100_reg > (pkts_ext << 1) + pkts_ext)
                q_next = QC_P80;
            else if (n100_reg > pkts_ext)
                raise_ok = 1'b0;
        end
        if (q_next == QC_NONE && raise_ok && valid_reg && pkts_reg > MIN_PKTS)
        begin
            if (target_reg == '0)
                q_next = QC_UP1ST;
            else if (!down_seen_reg || down_gt_up_reg)
                q_next = QC_UP;
        end
        if (force_reg && q_next == QC_NONE && target_reg == '0 && cur_reg != '0)
            q_next = QC_FORCE;
        up_next = (q_next == QC_UP1ST) || (q_next == QC_UP);
        hold_next = up_next ? (up_seen_reg && up_lt_dir_reg)
                            : (down_seen_reg && down_lt_dir_reg);
    end

    assign sts.skip = skip_reg;
    assign sts.adjust = (q_next != QC_NONE);
    assign sts.tgt_zero = (target_reg == '0);
    assign sts.div_cand = (target_reg != '0) && (cur_reg != '0);
    assign sts.hold = hold_reg;
    assign sts.step_up = step_up_reg;

    always_comb
    begin
        mul_a = '0;
        mul_q = '0;
        case (cmd.mul_sel)
            MUL_CUR_SEED:
            begin
                mul_a = MA'(cur_reg);
                mul_q = Q_SEED;
            end
            MUL_TGT_Q:
            begin
                mul_a = MA'(target_reg);
                mul_q = q_value(qcode_reg);
            end
            MUL_CUR_Q:
            begin
                mul_a = MA'(cur_reg);
                mul_q = q_value(qcode_reg);
            end
            MUL_PROD_DIV:
            begin
                mul_a = prod_reg[MA-1:0];
                mul_q = Q_DIVERG;
            end
            MUL_CUR_DIV:
            begin
                mul_a = MA'(cur_reg);
                mul_q = Q_DIVERG;
            end
            MUL_TGT_DIV:
            begin
                mul_a = MA'(target_reg);
                mul_q = Q_DIVERG;
            end
            default:
            begin
                mul_a = '0;
                mul_q = '0;
            end
        endcase
    end

    assign prod_full = FULL'(mul_a) * FULL'(mul_q);

    always_comb
    begin
        prev_ext = MA'(target_reg);
        nt_sel = nt_reg;
        if (step_up_reg)
        begin
            if (nt_reg < prev_ext || PW'(nt_reg) > prod_reg)
                nt_sel = prev_ext;
        end
        else if (nt_reg > prev_ext)
            nt_sel = prev_ext;
        nt_clamp = nt_sel;
        if (nt_sel != '0)
        begin
            if (min_reg != '0 && nt_sel < MA'(min_reg))
                nt_clamp = MA'(min_reg);
            else if (max_reg != '0 && nt_sel > MA'(max_reg))
                nt_clamp = MA'(max_reg);
        end
    end

    assign tgt_ext = EXT'(target_reg);
    assign cur_ext = EXT'(cur_reg);
    assign tgt_out = (tgt_ext > EXT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tgt_ext[FIELD_BITS-1:0];
    assign rate_out = notify_reg ? cur_ext[FIELD_BITS-1:0] : '0;
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
            window_reg <= WINDOW_RESET;
            force_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_MIN: min_reg <= sat_rate(EXT'(cfg_data));
                CFG_MAX: max_reg <= sat_rate(EXT'(cfg_data));
                CFG_WINDOW: window_reg <= cfg_data[WINDOW_BITS-1:0];
                CFG_FORCE: force_reg <= cfg_data[0];
                default: force_reg <= force_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            adj_time_reg <= '0;
            adj_seen_reg <= 1'b0;
            down_time_reg <= '0;
            down_seen_reg <= 1'b0;
            up_time_reg <= '0;
            up_seen_reg <= 1'b0;
            notify_reg <= 1'b0;
            dir_reg <= DIR_NONE;
        end
        else
        begin
            if (cmd.load)
            begin
                notify_reg <= 1'b0;
                dir_reg <= DIR_NONE;
            end
            if (cmd.seed_wr)
                target_reg <= sat_rate(EXT'(prod_reg));
            if (cmd.adj_wr)
            begin
                adj_time_reg <= now_reg;
                adj_seen_reg <= 1'b1;
            end
            if (cmd.apply)
            begin
                target_reg <= sat_rate(EXT'(nt_clamp));
                notify_reg <= 1'b1;
                if (step_up_reg)
                begin
                    up_time_reg <= now_reg;
                    up_seen_reg <= 1'b1;
                    dir_reg <= DIR_UP;
                end
                else
                begin
                    down_time_reg <= now_reg;
                    down_seen_reg <= 1'b1;
                    dir_reg <= DIR_DOWN;
                end
            end
            if (cmd.div_chk)
                notify_reg <= (MA'(target_reg) > nt_reg) || (prod_reg < PW'(cur_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= TIME_BITS'(s_tdata[31:0]);
            pkts_reg <= s_tdata[63:32];
            nacks_reg <= s_tdata[95:64];
            dur_reg <= s_tdata[127:96];
            rate_in_reg <= sat_rate(EXT'(s_tdata[159:128]));
        end
        if (cmd.eval)
        begin
            skip_reg <= (pkts_reg == '0) ||
                        (adj_seen_reg && el_adj < TIME_BITS'(HOLD_ALL_MS));
            valid_reg <= (dur_reg >= FIELD_BITS'(window_reg));
            cur_reg <= (dur_reg >= FIELD_BITS'(window_reg)) ? rate_in_reg : '0;
            n100_reg <= (nacks_ext << 6) + (nacks_ext << 5) + (nacks_ext << 2);
            down_gt_up_reg <= (el_down > TIME_BITS'(HOLD_UP_MS));
            down_lt_dir_reg <= (el_down < TIME_BITS'(HOLD_DIR_MS));
            up_lt_dir_reg <= (el_up < TIME_BITS'(HOLD_DIR_MS));
        end
        if (cmd.decide)
        begin
            qcode_reg <= q_next;
            hold_reg <= hold_next;
            step_up_reg <= up_next;
        end
        if (cmd.mul_sel != MUL_NONE)
            prod_reg <= prod_full[FULL-1:16];
        if (cmd.nt_latch)
            nt_reg <= prod_reg[MA-1:0];
        if (cmd.out_load)
            out_reg <= {5'd0, rate_out, tgt_out, dir_reg, notify_reg};
    end

endmodule

// ===== rtl/nack_driven_bitrate_adapter.sv =====
// Bitrate adapter driven by periodic receiver reports.
// Each word on the s_ channel is one report; each report yields exactly one
// result word on the m_ channel, in order, with the notify flag, the step
// direction, the current target bitrate and the measured rate behind it.
// Configuration registers are written through the cfg_ channel, which is
// always ready; write them only while no report is in flight.
// An ignored report goes from acceptance through the evaluate and decide
// states to the output register; the longest path seeds a first target
// and then raises it. The single shared Q1.16 multiplier forms the seed,
// the stepped target, the raise cap and the divergence-check products,
// one product per cycle.
// A new report is accepted once the previous one has reached the output
// register, so a stalled receiver holds one finished result while the next
// report is processed; processing then waits for the output to drain.
// Reset clears the target, all adjustment timestamps and the output valid,
// and returns the registers to their defaults (10 s window, no clamps).
module nack_driven_bitrate_adapter #(
    parameter int RATE_BITS = nba_pkg::DEF_RATE_BITS,
    parameter int TIME_BITS = nba_pkg::DEF_TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, pkt_count, nack_count, duration_ms, cur_rate_bps
    input  logic [nba_pkg::S_DATA_BITS-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // notify, direction, target_bps, reported_rate_bps, zero fill
    output logic [nba_pkg::M_DATA_BITS-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nba_pkg::FIELD_BITS-1:0]     cfg_data
);
    import nba_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    nba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    nba_dp #(
        .RATE_BITS (RATE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
